>>> hw/rtl/per_destination_packet_buffer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the per-destination packet buffer.
// ---------------------------------------------------------------------------
`ifndef PER_DESTINATION_PACKET_BUFFER_MACROS_SVH
`define PER_DESTINATION_PACKET_BUFFER_MACROS_SVH

// Clocked assertion with synchronous active-low reset as the disable term.
`define PDB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PDB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/pdb_pkg.sv
// ---------------------------------------------------------------------------
// pdb_pkg
// Shared types and constants of the per-destination packet buffer.
// ---------------------------------------------------------------------------
package pdb_pkg;

    localparam int unsigned NumDestDefault   = 16;
    localparam int unsigned QueueDepthDefault = 8;
    localparam int unsigned CapWidth          = 20;
    localparam int unsigned AddrWidth         = 32;
    localparam int unsigned LenWidth          = 16;
    localparam int unsigned HandleWidth       = 16;
    localparam logic [CapWidth-1:0] CapReset  = 20'd65536;

    // Operation codes of an input transaction.
    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_TAKE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Result kinds.
    typedef enum logic [2:0] {
        K_STORED    = 3'd0,
        K_EVICTED   = 3'd1,
        K_DROPPED   = 3'd2,
        K_DELIVERED = 3'd3,
        K_NOTHING   = 3'd4,
        K_ANSWER    = 3'd5
    } t_kind;

    // Result of the slot search handed from the lookup unit to the sequencer.
    typedef struct packed {
        logic hit;
        logic free_found;
    } t_search;

endpackage

>>> hw/rtl/per_destination_packet_buffer.sv
// ---------------------------------------------------------------------------
// per_destination_packet_buffer
// Packet descriptor FIFOs per destination sharing one byte budget.
// ---------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when i_start is high and o_busy is low.
//   Ops: store, take oldest, query; other codes yield no result. Each of
//   these yields one or more results, each shown for one cycle with o_strobe
//   high; o_last marks the final one. The receiver cannot stall; results are
//   accepted as they appear. The capacity register is written through
//   i_cfg_valid/o_cfg_ready while the block is idle.
// Sequencing:
//   A command first walks the destination table one slot per cycle through
//   the shared comparator. A query, a take that finds nothing and a store
//   dropped for a full table return to idle; their single result shows in
//   the first cycle with o_busy low. A delivering take passes S_READ, S_EVICT
//   and S_FIN; a store S_CHECK and S_FIN, plus S_READ, S_EVICT and S_CHECK
//   per evicted packet. The next command is taken once o_busy falls.
// Reset:
//   Synchronous active-low reset empties all queues, clears the byte total
//   and loads the capacity with 65536. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "per_destination_packet_buffer_macros.svh"

module per_destination_packet_buffer
    import pdb_pkg::*;
#(
    parameter int unsigned NUM_DEST    = NumDestDefault,
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [1:0]             i_op,
    input  logic [AddrWidth-1:0]   i_dest_addr,
    input  logic [LenWidth-1:0]    i_pkt_length,
    input  logic [HandleWidth-1:0] i_pkt_handle,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CapWidth-1:0]    i_cfg_data,
    output logic                   o_strobe,
    output logic [2:0]             o_kind,
    output logic [HandleWidth-1:0] o_out_handle,
    output logic [LenWidth-1:0]    o_out_length,
    output logic                   o_waiting,
    output logic [CapWidth-1:0]    o_bytes_used,
    output logic                   o_last
);
    localparam int unsigned SW  = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;
    localparam int unsigned SCW = $clog2(NUM_DEST + 1);
    localparam int unsigned PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MD  = NUM_DEST * QUEUE_DEPTH;
    localparam int unsigned MW  = (MD > 1) ? $clog2(MD) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_DISP  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_READ  = 7'b0010000,
        S_EVICT = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration.
    logic [CapWidth-1:0] r_cap;
    assign o_cfg_ready = (r_state == S_IDLE);

    // Latched command.
    t_op                   r_op;
    logic [AddrWidth-1:0]  r_addr;
    logic [LenWidth-1:0]   r_len;
    logic [HandleWidth-1:0] r_hnd;
    logic [SW-1:0]         r_slot;
    logic                  r_full_evict;

    // Per-destination state.
    logic [NUM_DEST-1:0]   r_sval;
    logic [AddrWidth-1:0]  r_saddr [NUM_DEST];
    logic [PW-1:0]         r_head  [NUM_DEST];
    logic [QCW-1:0]        r_cnt   [NUM_DEST];
    logic [CapWidth-1:0]   r_total;

    // Entry memory, one read port with registered data.
    logic [HandleWidth+LenWidth-1:0] r_mem [MD];
    logic [HandleWidth+LenWidth-1:0] r_rdata;
    logic                  w_we;
    logic [MW-1:0]         w_waddr, w_raddr;

    // Search unit.
    logic [SCW-1:0] w_sidx, w_hs, w_fs;
    logic           w_sdone, w_go;
    t_search        w_sres;
    logic [AddrWidth-1:0] w_saddr_rd;

    assign w_go = i_start && !o_busy;
    assign w_saddr_rd = r_saddr[w_sidx[SW-1:0]];

    pdb_search #(.NUM_DEST(NUM_DEST)) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_addr      (r_addr),
        .i_valid     (r_sval),
        .i_slot_addr (w_saddr_rd),
        .o_idx       (w_sidx),
        .o_done      (w_sdone),
        .o_res       (w_sres),
        .o_hit_slot  (w_hs),
        .o_free_slot (w_fs)
    );

    // Views of the current slot.
    logic [QCW-1:0] w_cnt;
    logic [PW-1:0]  w_head, w_head_nx, w_tail;
    logic [QCW:0]   w_tsum;
    logic [CapWidth:0] w_need;
    assign w_cnt  = r_cnt[r_slot];
    assign w_head = r_head[r_slot];
    assign w_head_nx = (QCW'(w_head) + 1'b1 >= QCW'(QUEUE_DEPTH)) ? '0 : w_head + 1'b1;
    assign w_tsum = (QCW+1)'(w_head) + (QCW+1)'(w_cnt);
    assign w_tail = (w_tsum >= (QCW+1)'(QUEUE_DEPTH)) ?
                    PW'(w_tsum - (QCW+1)'(QUEUE_DEPTH)) : PW'(w_tsum);
    assign w_need = {1'b0, r_total} + (CapWidth+1)'(r_len);
    assign w_raddr = MW'(r_slot) * MW'(QUEUE_DEPTH) + MW'(w_head);
    assign w_waddr = MW'(r_slot) * MW'(QUEUE_DEPTH) + MW'(w_tail);

    // Result register.
    logic                   r_stb, n_stb;
    t_kind                  r_kind, n_kind;
    logic [HandleWidth-1:0] r_oh, n_oh;
    logic [LenWidth-1:0]    r_ol, n_ol;
    logic                   r_ow, n_ow, r_olast, n_olast;

    logic [LenWidth-1:0]    w_elen;
    logic [HandleWidth-1:0] w_ehnd;
    assign w_ehnd = r_rdata[HandleWidth+LenWidth-1:LenWidth];
    assign w_elen = r_rdata[LenWidth-1:0];

    // Sequencer control decisions.
    logic w_push, w_pop, w_alloc, w_freeslot;
    logic [SW-1:0] n_slot;
    logic n_full_evict;

    always_comb begin
        n_state = r_state;
        n_stb = 1'b0; n_kind = K_STORED; n_oh = '0; n_ol = '0;
        n_ow = 1'b0;  n_olast = 1'b0;
        w_push = 1'b0; w_pop = 1'b0; w_alloc = 1'b0; w_freeslot = 1'b0;
        n_slot = r_slot; n_full_evict = r_full_evict;
        w_we = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_go) n_state = S_SRCH;
            end
            S_SRCH: begin
                if (w_sdone) n_state = S_DISP;
            end
            S_DISP: begin
                n_state = S_IDLE;
                n_slot  = w_sres.hit ? w_hs[SW-1:0] : w_fs[SW-1:0];
                unique case (r_op)
                    OP_STORE: begin
                        if (!w_sres.hit && !w_sres.free_found) begin
                            n_stb = 1'b1; n_kind = K_DROPPED; n_oh = r_hnd;
                            n_ol = r_len; n_olast = 1'b1;
                        end else begin
                            w_alloc = !w_sres.hit;
                            n_state = S_CHECK;
                            n_full_evict = w_sres.hit &&
                                (r_cnt[w_hs[SW-1:0]] >= QCW'(QUEUE_DEPTH));
                        end
                    end
                    OP_TAKE: begin
                        if (w_sres.hit) begin
                            n_state = S_READ;
                        end else begin
                            n_stb = 1'b1; n_kind = K_NOTHING; n_olast = 1'b1;
                        end
                    end
                    OP_QUERY: begin
                        n_stb = 1'b1; n_kind = K_ANSWER; n_olast = 1'b1;
                        n_ow = w_sres.hit;
                    end
                    default: ;
                endcase
            end
            S_CHECK: begin
                if (r_full_evict) begin
                    n_state = S_READ;
                end else if (w_need <= {1'b0, r_cap}) begin
                    w_push = 1'b1; w_we = 1'b1;
                    n_stb = 1'b1; n_kind = K_STORED; n_oh = r_hnd; n_ol = r_len;
                    n_ow = 1'b1; n_olast = 1'b1; n_state = S_FIN;
                end else if (w_cnt != '0) begin
                    n_state = S_READ;
                end else begin
                    n_stb = 1'b1; n_kind = K_DROPPED; n_oh = r_hnd; n_ol = r_len;
                    n_olast = 1'b1; w_freeslot = 1'b1; n_state = S_FIN;
                end
            end
            S_READ: begin
                n_state = S_EVICT;
            end
            S_EVICT: begin
                w_pop = 1'b1;
                n_oh = w_ehnd; n_ol = w_elen; n_stb = 1'b1;
                n_ow = (w_cnt != QCW'(1));
                if (r_op == OP_TAKE) begin
                    n_kind = K_DELIVERED; n_olast = 1'b1; n_state = S_FIN;
                    w_freeslot = (w_cnt == QCW'(1));
                end else begin
                    n_kind = K_EVICTED; n_full_evict = 1'b0; n_state = S_CHECK;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    // Bytes total seen by the result register.
    logic [CapWidth-1:0] n_total;
    always_comb begin
        n_total = r_total;
        if (w_push) n_total = r_total + CapWidth'(r_len);
        if (w_pop)  n_total = r_total - CapWidth'(w_elen);
    end

    // Control registers. A slot is freed only once its command has settled,
    // so a store that empties its queue by eviction and then fits keeps it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= CapReset;
            r_sval  <= '0;
            r_total <= '0;
            r_stb   <= 1'b0;
            for (int i = 0; i < NUM_DEST; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_stb   <= n_stb;
            r_total <= n_total;
            if (i_cfg_valid && o_cfg_ready) r_cap <= i_cfg_data;
            if (w_alloc) begin
                r_sval[n_slot] <= 1'b1;
                r_head[n_slot] <= '0;
                r_cnt[n_slot]  <= '0;
            end
            if (w_push) r_cnt[r_slot] <= w_cnt + 1'b1;
            if (w_pop) begin
                r_cnt[r_slot]  <= w_cnt - 1'b1;
                r_head[r_slot] <= w_head_nx;
            end
            if (w_freeslot) r_sval[r_slot] <= 1'b0;
        end
    end

    // Payload registers and memory.
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_op   <= t_op'(i_op);
            r_addr <= i_dest_addr;
            r_len  <= i_pkt_length;
            r_hnd  <= i_pkt_handle;
        end
        if (w_alloc) r_saddr[n_slot] <= r_addr;
        r_slot       <= n_slot;
        r_full_evict <= n_full_evict;
        if (w_we) r_mem[w_waddr] <= {r_hnd, r_len};
        r_rdata <= r_mem[w_raddr];
        r_kind  <= n_kind;
        r_oh    <= n_oh;
        r_ol    <= n_ol;
        r_ow    <= n_ow;
        r_olast <= n_olast;
    end

    assign o_strobe     = r_stb;
    assign o_kind       = r_kind;
    assign o_out_handle = r_oh;
    assign o_out_length = r_ol;
    assign o_waiting    = r_ow;
    assign o_bytes_used = r_total;
    assign o_last       = r_olast;

    // Checks on the sequencer.
    `PDB_ASSERT(a_no_start_when_busy_strobe, i_clk, i_rst_n,
        (r_state == S_IDLE) |-> !r_stb || r_olast,
        "Result strobe while idle must be a final result")
    `PDB_ASSERT(a_total_bounded, i_clk, i_rst_n,
        (r_stb && r_kind == K_STORED) |-> (o_bytes_used <= r_cap),
        "Stored packet exceeded the budget")
    `PDB_ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> (r_state == S_IDLE && !r_stb), "Reset did not return to idle")
endmodule

>>> hw/rtl/pdb_search.sv
// ---------------------------------------------------------------------------
// pdb_search
// Slot search: walks the destination table one slot per cycle with a single
// shared comparator, finding the lowest matching slot and the lowest free one.
// ---------------------------------------------------------------------------
module pdb_search
    import pdb_pkg::*;
#(
    parameter int unsigned NUM_DEST = NumDestDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [AddrWidth-1:0]        i_addr,
    input  logic [NUM_DEST-1:0]         i_valid,
    input  logic [AddrWidth-1:0]        i_slot_addr,
    output logic [$clog2(NUM_DEST+1)-1:0] o_idx,
    output logic                        o_done,
    output t_search                     o_res,
    output logic [$clog2(NUM_DEST+1)-1:0] o_hit_slot,
    output logic [$clog2(NUM_DEST+1)-1:0] o_free_slot
);
    localparam int unsigned CW = $clog2(NUM_DEST + 1);
    localparam int unsigned IW = (NUM_DEST > 1) ? $clog2(NUM_DEST) : 1;

    logic          r_run, n_run;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_hit, n_hit, r_free, n_free, r_done, n_done;
    logic [CW-1:0] r_hs, n_hs, r_fs, n_fs;
    logic [IW-1:0] w_i;
    logic          w_v;

    assign w_i = r_idx[IW-1:0];
    assign w_v = i_valid[w_i];

    // One slot compared per cycle; i_slot_addr is the addressed entry.
    always_comb begin
        n_run  = r_run;
        n_idx  = r_idx;
        n_hit  = r_hit;
        n_free = r_free;
        n_hs   = r_hs;
        n_fs   = r_fs;
        n_done = 1'b0;
        if (i_go) begin
            n_run  = 1'b1;
            n_idx  = '0;
            n_hit  = 1'b0;
            n_free = 1'b0;
        end else if (r_run) begin
            if (w_v && (i_slot_addr == i_addr) && !r_hit) begin
                n_hit = 1'b1;
                n_hs  = r_idx;
            end
            if (!w_v && !r_free) begin
                n_free = 1'b1;
                n_fs   = r_idx;
            end
            if (r_idx == CW'(NUM_DEST - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_idx  <= n_idx;
            r_hit  <= n_hit;
            r_free <= n_free;
        end
        r_hs <= n_hs;
        r_fs <= n_fs;
    end

    assign o_idx            = r_idx;
    assign o_done           = r_done;
    assign o_res.hit        = r_hit;
    assign o_res.free_found = r_free;
    assign o_hit_slot       = r_hs;
    assign o_free_slot      = r_fs;
endmodule

>>> dv/per_destination_packet_buffer_test.sv
// ---------------------------------------------------------------------------
// Per-destination packet buffer testbench
// Drives store, take, query and unused op codes with random gaps, predicts every
// result from a behavioral copy of the queues and checks each strobed result.
// ---------------------------------------------------------------------------

// One predicted or observed result.
typedef struct {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [15:0] length;
    logic        waiting;
    logic [19:0] bytes_used;
    logic        last;
} t_pdb_result;

// Scoreboard: behavioral queues and the list of pending results.
class pdb_scoreboard;
    logic [31:0] slot_addr  [16];
    bit          slot_used  [16];
    logic [15:0] ent_handle [128];
    logic [15:0] ent_length [128];
    int          head       [16];
    int          count      [16];
    logic [19:0] total;
    logic [19:0] capacity;
    t_pdb_result pending[$];
    int          errors;

    function new();
        errors = 0;
        capacity = pdb_pkg::CapReset;
        total = 0;
        for (int i = 0; i < 16; i++) begin
            slot_used[i] = 0;
            head[i] = 0;
            count[i] = 0;
        end
    endfunction

    function void push_result(logic [2:0] k, logic [15:0] h, logic [15:0] l, logic w);
        t_pdb_result r;
        r.kind = k;
        r.handle = h;
        r.length = l;
        r.waiting = w;
        r.bytes_used = total;
        r.last = 0;
        pending.push_back(r);
    endfunction

    function void pop_oldest(int s);
        int idx;
        idx = s * 8 + head[s];
        head[s] = (head[s] + 1) % 8;
        count[s]--;
        total = total - 20'(ent_length[idx]);
        push_result(pdb_pkg::K_EVICTED, ent_handle[idx], ent_length[idx], count[s] > 0);
    endfunction

    // Note an accepted command and queue the results it causes.
    function void note_command(logic [1:0] op, logic [31:0] addr, logic [15:0] len,
                               logic [15:0] hnd);
        int s;
        int n0;
        int idx;
        s = -1;
        n0 = pending.size();
        for (int i = 0; i < 16; i++)
            if (s < 0 && slot_used[i] && slot_addr[i] == addr) s = i;
        if (op == pdb_pkg::OP_STORE) begin
            if (s < 0) begin
                for (int i = 0; i < 16; i++)
                    if (s < 0 && !slot_used[i]) s = i;
                if (s >= 0) begin
                    slot_used[s] = 1;
                    slot_addr[s] = addr;
                    head[s] = 0;
                    count[s] = 0;
                end
            end
            if (s < 0) begin
                push_result(pdb_pkg::K_DROPPED, hnd, len, 0);
            end else begin
                if (count[s] >= 8) pop_oldest(s);
                forever begin
                    if (21'(total) + 21'(len) <= 21'(capacity)) begin
                        idx = s * 8 + (head[s] + count[s]) % 8;
                        ent_handle[idx] = hnd;
                        ent_length[idx] = len;
                        count[s]++;
                        total = total + 20'(len);
                        push_result(pdb_pkg::K_STORED, hnd, len, 1);
                        break;
                    end
                    if (count[s] > 0) begin
                        pop_oldest(s);
                    end else begin
                        push_result(pdb_pkg::K_DROPPED, hnd, len, 0);
                        break;
                    end
                end
                if (count[s] == 0) slot_used[s] = 0;
            end
        end else if (op == pdb_pkg::OP_TAKE) begin
            if (s >= 0 && count[s] > 0) begin
                pop_oldest(s);
                pending[pending.size()-1].kind = pdb_pkg::K_DELIVERED;
                if (count[s] == 0) slot_used[s] = 0;
            end else begin
                push_result(pdb_pkg::K_NOTHING, 0, 0, 0);
            end
        end else if (op == pdb_pkg::OP_QUERY) begin
            push_result(pdb_pkg::K_ANSWER, 0, 0, s >= 0 && count[s] > 0);
        end
        if (pending.size() > n0) pending[pending.size()-1].last = 1;
    endfunction

    // Compare one observed result with the oldest pending one.
    function void check_result(t_pdb_result got);
        t_pdb_result exp;
        if (pending.size() == 0) begin
            $error("unexpected result, kind %0d", got.kind);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.kind !== exp.kind) begin
            $error("kind expected %0d actual %0d", exp.kind, got.kind); errors++;
        end
        if (got.handle !== exp.handle) begin
            $error("out_handle expected %0h actual %0h", exp.handle, got.handle); errors++;
        end
        if (got.length !== exp.length) begin
            $error("out_length expected %0h actual %0h", exp.length, got.length); errors++;
        end
        if (got.waiting !== exp.waiting) begin
            $error("waiting expected %0d actual %0d", exp.waiting, got.waiting); errors++;
        end
        if (got.bytes_used !== exp.bytes_used) begin
            $error("bytes_used expected %0h actual %0h", exp.bytes_used, got.bytes_used);
            errors++;
        end
        if (got.last !== exp.last) begin
            $error("last expected %0d actual %0d", exp.last, got.last); errors++;
        end
    endfunction
endclass

module per_destination_packet_buffer_test;
    import pdb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_op;
    logic [31:0] i_dest_addr;
    logic [15:0] i_pkt_length;
    logic [15:0] i_pkt_handle;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [19:0] i_cfg_data;
    logic        o_strobe;
    logic [2:0]  o_kind;
    logic [15:0] o_out_handle;
    logic [15:0] o_out_length;
    logic        o_waiting;
    logic [19:0] o_bytes_used;
    logic        o_last;

    pdb_scoreboard board;
    logic [31:0]   dest_pool [6];
    int            burst_left;

    per_destination_packet_buffer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_op(i_op), .i_dest_addr(i_dest_addr), .i_pkt_length(i_pkt_length),
        .i_pkt_handle(i_pkt_handle), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data), .o_strobe(o_strobe),
        .o_kind(o_kind), .o_out_handle(o_out_handle), .o_out_length(o_out_length),
        .o_waiting(o_waiting), .o_bytes_used(o_bytes_used), .o_last(o_last)
    );

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result monitor: every strobed cycle is one result transaction.
    always @(posedge i_clk) begin
        t_pdb_result got;
        if (i_rst_n && o_strobe) begin
            got.kind = o_kind;
            got.handle = o_out_handle;
            got.length = o_out_length;
            got.waiting = o_waiting;
            got.bytes_used = o_bytes_used;
            got.last = o_last;
            board.check_result(got);
        end
    end

    // Issue one command; a random gap precedes a new burst.
    task automatic send_command(logic [1:0] op, logic [31:0] addr, logic [15:0] len,
                                logic [15:0] hnd);
        if (burst_left == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        i_start <= 1'b1;
        i_op <= op;
        i_dest_addr <= addr;
        i_pkt_length <= len;
        i_pkt_handle <= hnd;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        board.note_command(op, addr, len, hnd);
    endtask

    // Let the block drain, then write the capacity register.
    task automatic write_capacity(logic [19:0] cap);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        board.capacity = cap;
    endtask

    task automatic random_phase(int n);
        logic [1:0]  op;
        logic [31:0] addr;
        logic [15:0] len;
        int          pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            op = (pick < 55) ? OP_STORE : (pick < 80) ? OP_TAKE :
                 (pick < 95) ? OP_QUERY : OP_NONE;
            addr = ($urandom_range(0, 9) == 0) ? $urandom() : dest_pool[$urandom_range(0, 5)];
            len = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4000));
            send_command(op, addr, len, 16'($urandom()));
        end
    endtask

    initial begin
        board = new();
        burst_left = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_op = OP_STORE;
        i_dest_addr = '0;
        i_pkt_length = '0;
        i_pkt_handle = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        for (int i = 0; i < 6; i++) dest_pool[i] = $urandom();
        dest_pool[0] = 32'h0;
        dest_pool[1] = 32'hFFFF_FFFF;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every op, full queue, ignored op code.
        send_command(OP_TAKE, 32'h0, 16'h0, 16'h0);
        send_command(OP_QUERY, 32'h0, 16'h0, 16'h0);
        send_command(OP_STORE, 32'h0, 16'h0, 16'h0);
        send_command(OP_STORE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_command(OP_QUERY, 32'hFFFF_FFFF, 16'h0, 16'h0);
        send_command(OP_NONE, 32'h0, 16'h1, 16'h1);
        for (int i = 0; i < 9; i++) send_command(OP_STORE, 32'h5, 16'(i + 1), 16'(i + 100));
        send_command(OP_TAKE, 32'h0, 16'h0, 16'h0);
        send_command(OP_TAKE, 32'h0, 16'h0, 16'h0);
        // Fill the destination table, then overflow it.
        for (int i = 0; i < 16; i++) send_command(OP_STORE, 32'h100 + i, 16'h10, 16'(i));

        // Capacity lowered below the held total evicts only this destination.
        write_capacity(20'd1000);
        send_command(OP_STORE, 32'h5, 16'd900, 16'h77);
        write_capacity(20'd0);
        send_command(OP_STORE, 32'h0, 16'd0, 16'h1);
        send_command(OP_STORE, 32'h6, 16'd1, 16'h2);
        write_capacity(20'hFFFFF);
        random_phase(100);
        write_capacity(20'd8000);
        random_phase(100);
        write_capacity(20'd70000);
        random_phase(100);

        i_start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("per_destination_packet_buffer verification clean");
        end else begin
            $display("per_destination_packet_buffer verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #3000000;
        $display("per_destination_packet_buffer verification failed");
        $finish;
    end
endmodule

>>> per_destination_packet_buffer.f
+incdir+hw/rtl
hw/rtl/pdb_pkg.sv
hw/rtl/pdb_search.sv
hw/rtl/per_destination_packet_buffer.sv
dv/per_destination_packet_buffer_test.sv
